// ===== sv/hsd_pkg.sv =====
// Shared constants, types and parity-check functions for the Hamming syndrome decoder.
package hsd_pkg;

    localparam int WORD_W   = 8;
    localparam int PCOUNT_W = 3;
    localparam int ROWS     = 4;
    localparam int SYN_W    = 4;

    localparam logic [PCOUNT_W-1:0] PCOUNT_MIN   = 3'd1;
    localparam logic [PCOUNT_W-1:0] PCOUNT_MAX   = 3'd4;
    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 3'd4;

    // Parity-check rows as bit masks (bit c = column c), indexed by count-1, then row
    localparam logic [WORD_W-1:0] CHECK_ROWS [ROWS][ROWS] = '{
        '{8'h1F, 8'h00, 8'h00, 8'h00},
        '{8'h17, 8'h2E, 8'h00, 8'h00},
        '{8'h17, 8'h2E, 8'h4B, 8'h00},
        '{8'h17, 8'h2E, 8'h4B, 8'h8D}
    };

    // Code-length mask for each supported parity count
    localparam logic [WORD_W-1:0] LEN_MASK [ROWS] = '{8'h1F, 8'h3F, 8'h7F, 8'hFF};

    typedef struct packed {
        logic [WORD_W-1:0] corrected_word;
        logic              word_valid;
    } hsd_result_t;

    // Syndrome of a word against the selected matrix; unused rows give zero
    function automatic logic [SYN_W-1:0] hsd_syndrome(
        input logic [WORD_W-1:0] word,
        input logic [1:0]        row_sel
    );
        logic [SYN_W-1:0] syn;
        syn = '0;
        for (int r = 0; r < ROWS; r++) begin
            syn[r] = ^(word & CHECK_ROWS[row_sel][r]);
        end
        return syn;
    endfunction

    // True for a parity count the matrices cover
    function automatic logic hsd_supported(input logic [PCOUNT_W-1:0] pcount);
        return (pcount >= PCOUNT_MIN) && (pcount <= PCOUNT_MAX);
    endfunction

endpackage

// ===== sv/hsd_core.sv =====
// Combinational syndrome computation and single-bit correction for one codeword.
module hsd_core (
    input  logic [hsd_pkg::PCOUNT_W-1:0] parity_count,
    input  logic [hsd_pkg::WORD_W-1:0]   received_word,
    output hsd_pkg::hsd_result_t         result
);
    import hsd_pkg::*;

    logic [1:0]        row_sel;
    logic              supported;
    logic [WORD_W-1:0] masked_word;
    logic [SYN_W-1:0]  syn;
    logic [WORD_W-1:0] col_match;
    logic [WORD_W-1:0] flip_bit;

    assign row_sel     = 2'(parity_count - 3'd1);
    assign supported   = hsd_supported(parity_count);
    assign masked_word = received_word & LEN_MASK[row_sel];
    assign syn         = hsd_syndrome(masked_word, row_sel);

    // Compare the syndrome with every column; columns past the code length are all zero
    always_comb begin
        logic [SYN_W-1:0] col_syn;
        col_match = '0;
        for (int c = 0; c < WORD_W; c++) begin
            col_syn = '0;
            for (int r = 0; r < ROWS; r++) begin
                col_syn[r] = CHECK_ROWS[row_sel][r][c];
            end
            col_match[c] = (syn != '0) && (col_syn == syn);
        end
    end

    // Keep only the lowest matching column
    assign flip_bit = col_match & ~(col_match - 8'd1);

    // Correct the masked word for a supported count; pass the word through, marked invalid, for an unsupported count
    always_comb begin
        if (supported) begin
            result.corrected_word = masked_word ^ flip_bit;
            result.word_valid     = (syn == '0) || (col_match != '0);
        end else begin
            result.corrected_word = received_word;
            result.word_valid     = 1'b0;
        end
    end

endmodule

// ===== sv/hamming_syndrome_decoder.sv =====
// Top level: input register, syndrome decoder and result register with stream handshakes.
//
//  channel | direction | beat contents
//  s_      | in        | tdata[7:0] received_word
//  m_      | out       | tdata[7:0] corrected_word, tuser[0] word_valid
//  cfg_    | in        | wr_data[2:0] parity_count, written when wr_en is high
//
// One word per cycle sustained while m_tready stays high; the input register and the result
// register around the XOR trees lie between input beat and result beat.
// Reset clears both stage valid bits and sets parity_count to 4.
// A stall on m_tready holds the result register and backs up into the input
// register; s_tready drops only when both registers are full and blocked.
module hamming_syndrome_decoder (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [hsd_pkg::PCOUNT_W-1:0] cfg_wr_data,   // parity_count
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [hsd_pkg::WORD_W-1:0]   s_tdata,       // [7:0] received_word
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [hsd_pkg::WORD_W-1:0]   m_tdata,       // [7:0] corrected_word
    output logic                         m_tuser        // [0] word_valid
);
    import hsd_pkg::*;

    logic [PCOUNT_W-1:0] parity_count_reg;
    logic                in_valid_reg;
    logic [WORD_W-1:0]   in_word_reg;
    logic                out_valid_reg;
    hsd_result_t         out_result_reg;
    hsd_result_t         dec_result;
    logic                out_load;
    logic                in_load;

    // Advance the pipeline when the next stage is empty or draining
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    // Hold the parity count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_count_reg <= PCOUNT_RESET;
        end else if (cfg_wr_en) begin
            parity_count_reg <= cfg_wr_data;
        end
    end

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_word_reg <= s_tdata;
        end
    end

    hsd_core u_core (
        .parity_count  (parity_count_reg),
        .received_word (in_word_reg),
        .result        (dec_result)
    );

    // Result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            out_result_reg <= dec_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_result_reg.corrected_word;
    assign m_tuser  = out_result_reg.word_valid;

`ifndef NO_ASSERTIONS
    // A word in the input stage moves on whenever the result stage is empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
    else $error("input stage did not advance into empty result stage");

    // A result marked valid for a supported count has a zero syndrome
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && hsd_supported(parity_count_reg) |->
            hsd_syndrome(m_tdata, 2'(parity_count_reg - 3'd1)) == '0)
    else $error("valid result does not satisfy the parity checks");

    // Bits above the code length are cleared for a supported count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && hsd_supported(parity_count_reg) |->
            (m_tdata & ~LEN_MASK[2'(parity_count_reg - 3'd1)]) == '0)
    else $error("result has bits set above the code length");

    // An unsupported count never yields a valid result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !hsd_supported(parity_count_reg) |-> !m_tuser)
    else $error("result marked valid for unsupported parity count");
`endif

endmodule

// ===== verif/hamming_syndrome_decoder_test.sv =====
// Self-checking stream testbench for the Hamming syndrome decoder with random idling on both sides.
module hamming_syndrome_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_W     = hsd_pkg::WORD_W;
    localparam int PCOUNT_W   = hsd_pkg::PCOUNT_W;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_WORDS   = 100;
    localparam int MAX_REPORTS   = 10;

    // Parity-check rows as column masks, one table per parity count (1..4)
    localparam logic [7:0] CHECK_MASKS [4][4] = '{
        '{8'h1F, 8'h00, 8'h00, 8'h00},
        '{8'h17, 8'h2E, 8'h00, 8'h00},
        '{8'h17, 8'h2E, 8'h4B, 8'h00},
        '{8'h17, 8'h2E, 8'h4B, 8'h8D}
    };

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              ok;
    } decoded_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [PCOUNT_W-1:0] cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [WORD_W-1:0]   s_tdata     = '0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [WORD_W-1:0]   m_tdata;
    logic                m_tuser;

    decoded_t            pending_decodes [$];
    logic [PCOUNT_W-1:0] parity_count_model = 3'd4;
    bit                  src_idle_on  = 1'b1;
    bit                  sink_idle_on = 1'b1;
    int                  sink_stall_left = 0;
    int                  cycle_count  = 0;
    int                  mismatches   = 0;
    int                  words_sent   = 0;
    int                  words_checked = 0;
    int                  words_clean  = 0;
    int                  words_fixed  = 0;
    int                  words_bad    = 0;

    hamming_syndrome_decoder i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Decode one received word under the given parity count
    function automatic decoded_t decode_word(logic [7:0] rx, logic [2:0] pcount);
        decoded_t   res;
        logic [7:0] mask;
        logic [3:0] syn;
        logic [3:0] col_syn;
        int         len;
        int         tbl;
        bit         found;
        res.word = rx;
        res.ok   = 1'b0;
        if (pcount < hsd_pkg::PCOUNT_MIN || pcount > hsd_pkg::PCOUNT_MAX) begin
            return res;
        end
        tbl   = int'(pcount) - 1;
        len   = 4 + int'(pcount);
        mask  = 8'((1 << len) - 1);
        res.word = rx & mask;
        syn   = '0;
        for (int r = 0; r < int'(pcount); r++) begin
            syn[r] = ^(res.word & CHECK_MASKS[tbl][r]);
        end
        if (syn == 4'd0) begin
            res.ok = 1'b1;
            return res;
        end
        found = 1'b0;
        // Flip the first position whose column equals the syndrome
        for (int c = 0; c < len; c++) begin
            col_syn = '0;
            for (int r = 0; r < int'(pcount); r++) begin
                col_syn[r] = CHECK_MASKS[tbl][r][c];
            end
            if (!found && col_syn == syn) begin
                res.word[c] = ~res.word[c];
                res.ok      = 1'b1;
                found       = 1'b1;
            end
        end
        return res;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Drive one beat, wait for acceptance and queue its expected decode
    task automatic send_word(input logic [7:0] rx);
        int       gap;
        decoded_t exp_res;
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        exp_res = decode_word(rx, parity_count_model);
        pending_decodes.push_back(exp_res);
        words_sent++;
        if (!exp_res.ok) begin
            words_bad++;
        end else if (exp_res.word == (rx & 8'((1 << (4 + int'(parity_count_model))) - 1)))
        begin
            words_clean++;
        end else begin
            words_fixed++;
        end
    endtask

    // Hold the input idle until every pending result has come out
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_parity_count(input logic [2:0] value);
        drain_pipeline();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en          <= 1'b0;
        parity_count_model = value;
    endtask

    // Build a word that decodes clean under the current parity count
    function automatic logic [7:0] make_codeword();
        decoded_t   res;
        logic [7:0] w;
        for (int tries = 0; tries < 64; tries++) begin
            w   = 8'($urandom_range(0, 255));
            res = decode_word(w, parity_count_model);
            if (res.ok) begin
                return res.word;
            end
        end
        return 8'h00;
    endfunction

    // Random word: mostly codewords with zero, one or two flipped bits
    function automatic logic [7:0] make_random_word();
        logic [7:0] w;
        logic [7:0] mask;
        int         len;
        int         kind;
        int         a;
        int         b;
        if (parity_count_model < hsd_pkg::PCOUNT_MIN || parity_count_model > hsd_pkg::PCOUNT_MAX)
        begin
            return 8'($urandom_range(0, 255));
        end
        len  = 4 + int'(parity_count_model);
        mask = 8'((1 << len) - 1);
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            return 8'($urandom_range(0, 255));
        end
        w = make_codeword();
        if (kind >= 5) begin
            a = $urandom_range(0, len - 1);
            w[a] = ~w[a];
        end
        if (kind == 9) begin
            b = (a + $urandom_range(1, len - 1)) % len;
            w[b] = ~w[b];
        end
        // Junk above the code length must be ignored
        if ($urandom_range(0, 1) == 1) begin
            w = w | (8'($urandom_range(0, 255)) & ~mask);
        end
        return w;
    endfunction

    task automatic test_reset_default();
        send_word(8'h00);
        send_word(8'hFF);
        send_word(8'h10);
        send_word(8'h30);
        send_word(8'h80);
        drain_pipeline();
    endtask

    task automatic test_each_count();
        for (int pc = 1; pc <= 4; pc++) begin
            write_parity_count(3'(pc));
            send_word(8'h00);
            send_word(8'hFF);
            send_word(8'h01 << (3 + pc));
            send_word(8'h03);
        end
        drain_pipeline();
    endtask

    task automatic test_unsupported_counts();
        write_parity_count(3'd0);
        send_word(8'hA5);
        write_parity_count(3'd7);
        send_word(8'hFF);
        write_parity_count(3'd5);
        send_word(8'h00);
        write_parity_count(3'd6);
        send_word(8'h5A);
        drain_pipeline();
    endtask

    task automatic test_random_traffic();
        logic [2:0] pc;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            pc = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(1, 4));
            write_parity_count(pc);
            // Some phases run with no idling on one or both sides
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                send_word(make_random_word());
            end
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        drain_pipeline();
    endtask

    // Stall the result side at random
    always @(posedge aclk) begin
        if (sink_stall_left == 0 && sink_idle_on && $urandom_range(0, 3) == 0) begin
            sink_stall_left = pick_gap();
        end
        if (sink_stall_left > 0) begin
            sink_stall_left = sink_stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest pending decode
    always @(posedge aclk) begin
        decoded_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_decodes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result beat: word %02h valid %0b", m_tdata, m_tuser);
                end
            end else begin
                exp_res = pending_decodes.pop_front();
                words_checked++;
                if (m_tdata !== exp_res.word || m_tuser !== exp_res.ok) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: expected word %02h valid %0b, got word %02h valid %0b",
                                 exp_res.word, exp_res.ok, m_tdata, m_tuser);
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_default();
        test_each_count();
        test_unsupported_counts();
        test_random_traffic();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_decodes.size() != 0) begin
            mismatches += pending_decodes.size();
            $display("%0d results never arrived", pending_decodes.size());
        end
        $display("%0d words decoded under parity counts 0 to 7 with random idling on both sides",
                 words_checked);
        $display("%0d passed clean, %0d corrected, %0d flagged invalid; %0d errors",
                 words_clean, words_fixed, words_bad, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/hsd_pkg.sv
sv/hsd_core.sv
sv/hamming_syndrome_decoder.sv
verif/hamming_syndrome_decoder_test.sv
